// ===== sv/octkey_pkg.sv =====
`timescale 1ns / 1ps
// octkey_pkg: shared widths, reset value and the stage record of the octree key pipeline
// used by octkey_entry, octkey_cell and octree_cell_key_generator, depends on nothing

package octkey_pkg;

  localparam int AXES       = 3;
  localparam int POS_BITS   = 32;
  localparam int EDGE_BITS  = 32;
  localparam int KEY_BITS   = 63;
  localparam int OCT_BITS   = 3;
  localparam int IN_TDATA   = 96;
  localparam int OUT_TDATA  = 64;

  localparam logic [EDGE_BITS-1:0] EDGE_RESET = 32'd65536;

  // one point in flight: per-axis saturation and division residue, key so far
  typedef struct packed {
    logic [AXES-1:0]                sat;
    logic [AXES-1:0][EDGE_BITS-1:0] rem;
    logic [KEY_BITS-1:0]            key;
    logic                           last;
  } stage_t;

endpackage

// ===== sv/octree_cell_key_generator.sv =====
`timescale 1ns / 1ps
// octree_cell_key_generator: top level, entry stage, chain of level cells, output register
// depends on octkey_pkg, octkey_entry, octkey_cell

// Turns each point (three unsigned coordinates in the units of the configured cube
// edge) into a 3*DEPTH-bit octree cell key, level zero in the top three bits, x in
// the low bit of each octant digit. The midpoint tests are exact: each level is one
// restoring division step of coordinate by edge, held in a chain of DEPTH identical
// cells, one cell per level. A coordinate at or beyond the edge gives all-ones bits
// on its axis; an edge of zero gives an all-ones key. Every stage is a single register
// that moves each cycle, so the block takes one point every cycle while the output is
// accepted; when a stalled output lets the skid register fill, the input waits until
// the skid has drained. Each key passes through the entry compare register, which loads
// at the accepting edge, then the DEPTH cells and the output register. tlast is carried
// alongside. Write box_edge only while no point is in flight.

module octree_cell_key_generator #(
  parameter int DEPTH      = 21,
  parameter int COORD_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration: box_edge
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [octkey_pkg::EDGE_BITS-1:0]   cfg_data,
  // input points
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [octkey_pkg::IN_TDATA-1:0]    s_axis_tdata,  // pos_x, pos_y, pos_z
  input  logic                               s_axis_tlast,  // batch_last_in
  // output keys
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [octkey_pkg::OUT_TDATA-1:0]   m_axis_tdata,  // cell_key, zero pad bit
  output logic                               m_axis_tlast   // batch_last_out
);

  logic [octkey_pkg::EDGE_BITS-1:0] box_edge;

  // pipeline advance: the whole chain moves unless the skid register is full
  logic adv;

  logic [DEPTH:0]     vld;
  octkey_pkg::stage_t stg [DEPTH+1];

  logic [octkey_pkg::AXES-1:0][octkey_pkg::POS_BITS-1:0] pos;

  logic                            out_valid;
  logic [octkey_pkg::KEY_BITS-1:0] out_key;
  logic                            out_last;
  logic                            skid_valid;
  logic [octkey_pkg::KEY_BITS-1:0] skid_key;
  logic                            skid_last;
  logic                            take;

  // configuration register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_edge <= octkey_pkg::EDGE_RESET;
    end else if (cfg_valid) begin
      box_edge <= cfg_data;
    end
  end

  assign adv           = !skid_valid;
  assign s_axis_tready = adv;

  // unpack coordinates, x in the low word
  always_comb begin
    for (int a = 0; a < octkey_pkg::AXES; a++) begin
      pos[a] = s_axis_tdata[a*octkey_pkg::POS_BITS +: octkey_pkg::POS_BITS];
    end
  end

  octkey_entry #(
    .COORD_BITS (COORD_BITS)
  ) u_entry (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_axis_tvalid),
    .pos       (pos),
    .last      (s_axis_tlast),
    .box_edge  (box_edge),
    .out_valid (vld[0]),
    .out_stage (stg[0])
  );

  // one cell per octree level, each hands its point to the next every cycle that the chain advances
  for (genvar d = 0; d < DEPTH; d++) begin : g_level
    octkey_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .box_edge  (box_edge),
      .in_valid  (vld[d]),
      .in_stage  (stg[d]),
      .out_valid (vld[d+1]),
      .out_stage (stg[d+1])
    );
  end

  // output register with a skid behind it, so tready does not depend on
  // downstream ready within the cycle
  assign take = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      out_valid  <= skid_valid || vld[DEPTH];
      skid_valid <= 1'b0;
    end else if (vld[DEPTH] && adv) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_key  <= skid_key;
        out_last <= skid_last;
      end else begin
        out_key  <= stg[DEPTH].key;
        out_last <= stg[DEPTH].last;
      end
    end else if (adv) begin
      skid_key  <= stg[DEPTH].key;
      skid_last <= stg[DEPTH].last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(octkey_pkg::OUT_TDATA-octkey_pkg::KEY_BITS){1'b0}}, out_key};
  assign m_axis_tlast  = out_last;

  // skid only fills behind a stalled output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a key while the output register is empty");

  // a stalled key in the skid moves forward once the output is taken
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_axis_tready) |=> (out_valid && !skid_valid))
    else $error("skid register did not drain into the output register");

  // no key appears right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !skid_valid && (vld == '0)))
    else $error("pipeline holds a point after reset");

endmodule

// ===== sv/octkey_entry.sv =====
`timescale 1ns / 1ps
// octkey_entry: front stage, masks the coordinates and checks them against the edge
// depends on octkey_pkg

module octkey_entry #(
  parameter int COORD_BITS = 32
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      adv,
  input  logic                                      in_valid,
  input  logic [octkey_pkg::AXES-1:0][octkey_pkg::POS_BITS-1:0] pos,
  input  logic                                      last,
  input  logic [octkey_pkg::EDGE_BITS-1:0]          box_edge,
  output logic                                      out_valid,
  output octkey_pkg::stage_t                        out_stage
);

  localparam int USED_BITS = (COORD_BITS < octkey_pkg::POS_BITS) ?
                             COORD_BITS : octkey_pkg::POS_BITS;
  localparam logic [octkey_pkg::POS_BITS-1:0] COORD_MASK =
    {octkey_pkg::POS_BITS{1'b1}} >> (octkey_pkg::POS_BITS - USED_BITS);

  logic [octkey_pkg::AXES-1:0][octkey_pkg::POS_BITS-1:0] coord;
  octkey_pkg::stage_t stage_next;

  always_comb begin
    stage_next = '0;
    for (int a = 0; a < octkey_pkg::AXES; a++) begin
      coord[a] = pos[a] & COORD_MASK;
      // at or beyond the edge: every later midpoint test passes
      stage_next.sat[a] = (coord[a] >= box_edge);
      stage_next.rem[a] = coord[a];
    end
    stage_next.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_stage <= stage_next;
    end
  end

endmodule

// ===== sv/octkey_cell.sv =====
`timescale 1ns / 1ps
// octkey_cell: one octree level, one restoring division step per axis
// depends on octkey_pkg

module octkey_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic [octkey_pkg::EDGE_BITS-1:0] box_edge,
  input  logic                             in_valid,
  input  octkey_pkg::stage_t               in_stage,
  output logic                             out_valid,
  output octkey_pkg::stage_t               out_stage
);

  logic [octkey_pkg::AXES-1:0][octkey_pkg::EDGE_BITS:0] dbl;
  logic [octkey_pkg::AXES-1:0][octkey_pkg::EDGE_BITS:0] diff;
  logic [octkey_pkg::OCT_BITS-1:0] oct;
  octkey_pkg::stage_t stage_next;

  always_comb begin
    stage_next = in_stage;
    for (int a = 0; a < octkey_pkg::AXES; a++) begin
      // residue below edge unless saturated, and EDGE_BITS wide, so doubling fits one extra bit
      dbl[a]  = {in_stage.rem[a], 1'b0};
      diff[a] = dbl[a] - {1'b0, box_edge};
      oct[a]  = in_stage.sat[a] || (dbl[a] >= {1'b0, box_edge});
      stage_next.rem[a] = oct[a] ? diff[a][octkey_pkg::EDGE_BITS-1:0]
                                 : dbl[a][octkey_pkg::EDGE_BITS-1:0];
    end
    stage_next.key = {in_stage.key[octkey_pkg::KEY_BITS-octkey_pkg::OCT_BITS-1:0], oct};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_stage <= stage_next;
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for octree_cell_key_generator, streams points in and checks keys
// depends on octkey_pkg and octree_cell_key_generator

module tb;

  localparam int DEPTH       = 21;
  localparam int COORD_BITS  = 32;
  localparam int RUN_LIMIT   = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int REPORT_CAP  = 100;
  // drain margin for wait_drained, after the top-level pipeline: entry register, DEPTH cells, output register
  localparam int PIPE_DEPTH  = DEPTH + 1;
  localparam logic [63:0] COORD_MASK = (64'd1 << COORD_BITS) - 64'd1;

  // one point as the sender sees it
  typedef struct packed {
    logic [octkey_pkg::POS_BITS-1:0] x;
    logic [octkey_pkg::POS_BITS-1:0] y;
    logic [octkey_pkg::POS_BITS-1:0] z;
    logic                            last;
  } point_t;

  // one key as it should come out
  typedef struct packed {
    logic [octkey_pkg::KEY_BITS-1:0] key;
    logic                            last;
  } key_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [octkey_pkg::EDGE_BITS-1:0] cfg_data  = '0;

  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [octkey_pkg::IN_TDATA-1:0]  s_axis_tdata  = '0;  // pos_x, pos_y, pos_z
  logic                             s_axis_tlast  = 1'b0;  // batch_last_in

  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [octkey_pkg::OUT_TDATA-1:0] m_axis_tdata;  // cell_key, zero pad bit
  logic                             m_axis_tlast;  // batch_last_out

  // points waiting to be offered, keys waiting to come out
  point_t   point_queue[$];
  key_rec_t expected_keys[$];

  // the bench's own copy of the box_edge register
  logic [octkey_pkg::EDGE_BITS-1:0] box_edge_now = octkey_pkg::EDGE_RESET;

  int unsigned points_sent   = 0;
  int unsigned keys_checked  = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned edge_writes   = 0;
  int unsigned backpressured = 0;
  int unsigned cycle_cnt     = 0;

  // sender burst state
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;

  // receiver stall state
  int unsigned rx_mode      = 0;
  int unsigned rx_mode_left = 50;
  int unsigned rx_phase     = 0;
  int unsigned hold_left    = 0;
  int unsigned next_hold_at = 300;

  key_rec_t want;

  octree_cell_key_generator #(
    .DEPTH      (DEPTH),
    .COORD_BITS (COORD_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  // exact octree descent: at each level every axis compares coord * 2^(lvl+1)
  // against the odd multiple of the edge that marks the middle of its current cell
  function automatic key_rec_t octree_key(input point_t p,
                                          input logic [octkey_pkg::EDGE_BITS-1:0] span);
    logic [63:0] coord [3];
    logic [63:0] idx [3];
    logic [63:0] scaled;
    logic [63:0] midpoint;
    logic [2:0]  octant;
    key_rec_t    r;
    coord[0] = {32'd0, p.x} & COORD_MASK;
    coord[1] = {32'd0, p.y} & COORD_MASK;
    coord[2] = {32'd0, p.z} & COORD_MASK;
    for (int a = 0; a < 3; a++) idx[a] = 64'd0;
    r.key  = '0;
    r.last = p.last;
    for (int lvl = 0; lvl < DEPTH; lvl++) begin
      for (int a = 0; a < 3; a++) begin
        scaled    = coord[a] << (lvl + 1);
        midpoint  = (64'd2 * idx[a] + 64'd1) * {32'd0, span};
        octant[a] = (scaled >= midpoint);
        idx[a]    = 64'd2 * idx[a] + {63'd0, octant[a]};
      end
      // newest digit goes in at the bottom, so level zero ends up on top
      r.key = {r.key[octkey_pkg::KEY_BITS-4:0], octant};
    end
    return r;
  endfunction

  // one coordinate, shaped to land on cell boundaries as often as inside cells
  function automatic logic [octkey_pkg::POS_BITS-1:0] pick_coord(
    input logic [octkey_pkg::EDGE_BITS-1:0] span);
    logic [63:0] v;
    logic [63:0] k;
    int unsigned m;
    case ($urandom_range(0, 9))
      0, 1: v = {32'd0, $urandom};
      2, 3, 4: begin
        if (span == '0) v = {32'd0, $urandom};
        else v = {$urandom, $urandom} % {32'd0, span};
      end
      5, 6: begin
        // near a fraction k / 2^m of the edge, one unit either side
        m = $urandom_range(1, DEPTH);
        k = 64'($urandom_range(0, 1 << m));
        v = ((k * {32'd0, span}) >> m) + 64'($urandom_range(0, 2)) - 64'd1;
      end
      7:       v = {32'd0, span} + 64'($urandom_range(0, 2)) - 64'd1;
      8:       v = 64'($urandom_range(0, 3));
      default: v = 64'(32'hFFFF_FFFF - $urandom_range(0, 3));
    endcase
    return v[octkey_pkg::POS_BITS-1:0];
  endfunction

  task automatic queue_point(input logic [octkey_pkg::POS_BITS-1:0] x,
                             input logic [octkey_pkg::POS_BITS-1:0] y,
                             input logic [octkey_pkg::POS_BITS-1:0] z, input logic last);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.last = last;
    point_queue.insert(point_queue.size(), p);
  endtask

  task automatic queue_random_points(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      queue_point(pick_coord(box_edge_now), pick_coord(box_edge_now), pick_coord(box_edge_now),
                  ($urandom_range(0, 7) == 0));
    end
  endtask

  // waits until every queued point went in and every key came out, then lets the pipe settle
  task automatic wait_drained();
    while (point_queue.size() != 0 || s_axis_tvalid || expected_keys.size() != 0)
      @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  // one transaction on the config channel, only ever issued with the pipe empty
  task automatic write_box_edge(input logic [octkey_pkg::EDGE_BITS-1:0] span);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= span;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    box_edge_now = span;
    edge_writes++;
  endtask

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // sender: bursts of random length, random gaps between them; tvalid never drops
  // while a transaction is still pending
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_keys.insert(expected_keys.size(), octree_key(point_queue[0], box_edge_now));
        void'(point_queue.pop_front());
        points_sent++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // about one burst in four, chosen at random, runs back to back with no gap
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        backpressured++;
      end else if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (point_queue.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {point_queue[0].z, point_queue[0].y, point_queue[0].x};
        s_axis_tlast  <= point_queue[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: switches between stall patterns, and now and then holds off for a
  // long stretch so the pipe fills and pushes back on the sender
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (points_sent >= next_hold_at) begin
      next_hold_at  = next_hold_at + 400;
      hold_left     = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left--;
      end
      rx_phase++;
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= (rx_phase % 3 == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // checker: every key transaction against the oldest prediction, field by field
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      keys_checked++;
      if (expected_keys.size() == 0) begin
        report_mismatch($sformatf("key %h arrived with none expected", m_axis_tdata));
      end else begin
        want = expected_keys.pop_front();
        if (m_axis_tdata[octkey_pkg::KEY_BITS-1:0] !== want.key)
          report_mismatch($sformatf("cell_key %h, expected %h",
                                    m_axis_tdata[octkey_pkg::KEY_BITS-1:0], want.key));
        if (m_axis_tdata[octkey_pkg::OUT_TDATA-1:octkey_pkg::KEY_BITS] !== '0)
          report_mismatch($sformatf("pad bit %b, expected 0",
                          m_axis_tdata[octkey_pkg::OUT_TDATA-1:octkey_pkg::KEY_BITS]));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("batch_last_out %b, expected %b", m_axis_tlast, want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d keys still outstanding",
               cycle_cnt, expected_keys.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset edge 65536: origin, just inside and at the edge, exact midpoints,
    // out-of-range coordinates, alternating bit patterns
    queue_point(32'd0, 32'd0, 32'd0, 1'b0);
    queue_point(32'd65535, 32'd65535, 32'd65535, 1'b1);
    queue_point(32'd65536, 32'd65536, 32'd65536, 1'b0);
    queue_point(32'd32768, 32'd0, 32'd65535, 1'b0);
    queue_point(32'd32767, 32'd32769, 32'd16384, 1'b0);
    queue_point(32'hFFFF_FFFF, 32'd0, 32'd1, 1'b0);
    queue_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 1'b1);
    queue_point(32'd1, 32'd2, 32'd4, 1'b0);
    queue_point(32'd49152, 32'd8192, 32'd57344, 1'b1);
    queue_random_points(150);
    wait_drained();

    // smallest edge: everything but zero saturates
    write_box_edge(32'd1);
    queue_point(32'd0, 32'd0, 32'd0, 1'b0);
    queue_point(32'd1, 32'd0, 32'd0, 1'b1);
    queue_point(32'hFFFF_FFFF, 32'd1, 32'd0, 1'b0);
    queue_random_points(140);
    wait_drained();

    // largest edge: largest products in the compare
    write_box_edge(32'hFFFF_FFFF);
    queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_point(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b0);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b1);
    queue_point(32'd0, 32'd0, 32'd0, 1'b0);
    queue_random_points(140);
    wait_drained();

    // zero edge: all compares pass, key is all ones
    write_box_edge(32'd0);
    queue_point(32'd0, 32'd0, 32'd0, 1'b0);
    queue_point(32'd1, 32'hFFFF_FFFF, 32'd12345, 1'b1);
    queue_random_points(60);
    wait_drained();

    // an edge of three, a random odd edge, a random power of two and a random edge from 2 to 1000
    write_box_edge(32'd3);
    queue_random_points(140);
    wait_drained();

    write_box_edge($urandom | 32'd1);
    queue_random_points(140);
    wait_drained();

    write_box_edge(32'd1 << $urandom_range(0, 31));
    queue_random_points(140);
    wait_drained();

    write_box_edge(32'($urandom_range(2, 1000)));
    queue_random_points(140);
    wait_drained();

    $display("%0d points sent, %0d keys checked, %0d box_edge writes (zero, one, max included)",
             points_sent, keys_checked, edge_writes);
    $display("input held off by output backpressure for %0d cycles", backpressured);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
